// File: design/pbdec_pkg.sv
// ----------------------------------------------------------------------------
// pbdec_pkg
// Shared types and constants of the image record field decoder.
// ----------------------------------------------------------------------------
package pbdec_pkg;

  localparam int LENGTH_BITS      = 32;
  localparam int MAX_VARINT_BYTES = 10;
  localparam int ACC_W            = 64;
  localparam int POS_W            = $clog2(MAX_VARINT_BYTES + 1);
  localparam int FN_W             = 29;
  localparam int FLD_W            = 3;

  typedef enum logic [3:0] {
    K_CHANNELS     = 4'd0,
    K_HEIGHT       = 4'd1,
    K_WIDTH        = 4'd2,
    K_LABEL        = 4'd3,
    K_ENCODED      = 4'd4,
    K_FLOAT        = 4'd5,
    K_IMGLEN       = 4'd6,
    K_IMGBYTE      = 4'd7,
    K_BADTYPE      = 4'd8,
    K_UNKNOWN      = 4'd9,
    K_LONGVARINT   = 4'd10,
    K_BIGLENGTH    = 4'd11,
    K_ENDCLEAN     = 4'd12,
    K_ENDTRUNCATED = 4'd13
  } kind_t;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic [FN_W-1:0] FN_CHANNELS = FN_W'(1);
  localparam logic [FN_W-1:0] FN_HEIGHT   = FN_W'(2);
  localparam logic [FN_W-1:0] FN_WIDTH    = FN_W'(3);
  localparam logic [FN_W-1:0] FN_IMAGE    = FN_W'(4);
  localparam logic [FN_W-1:0] FN_LABEL    = FN_W'(5);
  localparam logic [FN_W-1:0] FN_FLOAT    = FN_W'(6);
  localparam logic [FN_W-1:0] FN_ENCODED  = FN_W'(7);

  typedef struct packed {
    kind_t            kind;
    logic [31:0]      value;
    logic [FN_W-1:0]  field_number;
    logic [2:0]       wire_type;
    logic             message_end;
  } res_t;

endpackage

// File: design/pbdec_if.sv
// ----------------------------------------------------------------------------
// pbdec_if
// Valid/ready channels of the decoder: byte input and decoded record output.
// ----------------------------------------------------------------------------
interface pbdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pbdec_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [31:0] value;
  logic [28:0] field_number;
  logic [2:0]  wire_type;
  logic        message_end;

  modport source (output valid, output kind, output value, output field_number,
                  output wire_type, output message_end, input ready);
  modport sink   (input valid, input kind, input value, input field_number,
                  input wire_type, input message_end, output ready);
endinterface

// File: design/pbdec_core.sv
// ----------------------------------------------------------------------------
// pbdec_core
// Parser state and per-byte decode: tag, varint, length, bytes and fixed32.
// ----------------------------------------------------------------------------
module pbdec_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output logic            res_valid,
  output pbdec_pkg::res_t res
);
  import pbdec_pkg::*;

  typedef enum logic [2:0] {
    PH_TAG   = 3'd0,
    PH_VAL   = 3'd1,
    PH_LEN   = 3'd2,
    PH_BYTES = 3'd3,
    PH_FIX   = 3'd4,
    PH_HALT  = 3'd5
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [FLD_W-1:0]       fld_r, fld_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;

  logic [POS_W+2:0]       shift_full;
  logic [5:0]             shamt;
  logic [ACC_W-1:0]       acc_or;
  logic [ACC_W-1:0]       acc_fix;
  logic [POS_W-1:0]       pos_inc;
  logic                   vdone;
  logic                   vlong;
  logic [FN_W-1:0]        tag_fn;
  logic [2:0]             tag_wt;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   hit;
  logic                   trunc;

  assign shift_full = {pos_r, 3'b000} - {3'b000, pos_r};
  assign shamt      = shift_full[5:0];
  assign acc_or     = acc_r | ({{(ACC_W-7){1'b0}}, data_byte[6:0]} << shamt);
  assign acc_fix    = acc_r | ({{(ACC_W-8){1'b0}}, data_byte} << {pos_r[1:0], 3'b000});
  assign pos_inc    = pos_r + POS_W'(1);
  assign vdone      = !data_byte[7];
  assign vlong      = data_byte[7] && (pos_inc >= POS_W'(MAX_VARINT_BYTES));
  assign tag_fn     = acc_or[31:3];
  assign tag_wt     = acc_or[2:0];
  assign rem_dec    = (rem_r != '0) ? rem_r - LENGTH_BITS'(1) : rem_r;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    pos_nxt   = pos_r;
    fld_nxt   = fld_r;
    rem_nxt   = rem_r;
    hit       = 1'b0;
    res       = '0;
    trunc     = 1'b0;

    case (phase_r)
      PH_TAG: begin
        if (pos_r == '0 && data_byte == 8'h00) begin
          phase_nxt = PH_HALT;
        end else if (vlong) begin
          hit       = 1'b1;
          res.kind  = K_LONGVARINT;
          phase_nxt = PH_HALT;
          acc_nxt   = acc_or;
          pos_nxt   = pos_inc;
        end else if (!vdone) begin
          acc_nxt = acc_or;
          pos_nxt = pos_inc;
        end else begin
          acc_nxt = '0;
          pos_nxt = '0;
          fld_nxt = '0;
          res.field_number = tag_fn;
          res.wire_type    = tag_wt;
          if (tag_fn == FN_CHANNELS || tag_fn == FN_HEIGHT || tag_fn == FN_WIDTH ||
              tag_fn == FN_LABEL || tag_fn == FN_ENCODED) begin
            if (tag_wt != WT_VARINT) begin
              hit      = 1'b1;
              res.kind = K_BADTYPE;
            end else begin
              fld_nxt   = tag_fn[FLD_W-1:0];
              phase_nxt = PH_VAL;
            end
          end else if (tag_fn == FN_IMAGE) begin
            if (tag_wt != WT_LEN) begin
              hit      = 1'b1;
              res.kind = K_BADTYPE;
            end else begin
              fld_nxt   = tag_fn[FLD_W-1:0];
              phase_nxt = PH_LEN;
            end
          end else if (tag_fn == FN_FLOAT) begin
            if (tag_wt != WT_FIXED32) begin
              hit      = 1'b1;
              res.kind = K_BADTYPE;
            end else begin
              fld_nxt   = tag_fn[FLD_W-1:0];
              phase_nxt = PH_FIX;
            end
          end else begin
            hit       = 1'b1;
            res.kind  = K_UNKNOWN;
            phase_nxt = PH_HALT;
          end
        end
      end

      PH_VAL: begin
        res.field_number = FN_W'(fld_r);
        res.wire_type    = WT_VARINT;
        if (vlong) begin
          hit       = 1'b1;
          res.kind  = K_LONGVARINT;
          phase_nxt = PH_HALT;
          acc_nxt   = acc_or;
          pos_nxt   = pos_inc;
        end else if (vdone) begin
          hit       = 1'b1;
          res.value = acc_or[31:0];
          case (FN_W'(fld_r))
            FN_CHANNELS: res.kind = K_CHANNELS;
            FN_HEIGHT:   res.kind = K_HEIGHT;
            FN_WIDTH:    res.kind = K_WIDTH;
            FN_LABEL:    res.kind = K_LABEL;
            default: begin
              res.kind  = K_ENCODED;
              res.value = {31'd0, acc_or[31:0] != 32'd0};
            end
          endcase
          phase_nxt = PH_TAG;
          acc_nxt   = '0;
          pos_nxt   = '0;
          fld_nxt   = '0;
        end else begin
          acc_nxt = acc_or;
          pos_nxt = pos_inc;
        end
      end

      PH_LEN: begin
        res.field_number = FN_IMAGE;
        res.wire_type    = WT_LEN;
        if (vlong) begin
          hit       = 1'b1;
          res.kind  = K_LONGVARINT;
          phase_nxt = PH_HALT;
          acc_nxt   = acc_or;
          pos_nxt   = pos_inc;
        end else if (vdone) begin
          hit       = 1'b1;
          res.value = acc_or[31:0];
          if ((acc_or >> LENGTH_BITS) != '0) begin
            res.kind  = K_BIGLENGTH;
            phase_nxt = PH_HALT;
            acc_nxt   = acc_or;
          end else begin
            res.kind = K_IMGLEN;
            acc_nxt  = '0;
            pos_nxt  = '0;
            rem_nxt  = acc_or[LENGTH_BITS-1:0];
            if (acc_or != '0) begin
              phase_nxt = PH_BYTES;
            end else begin
              phase_nxt = PH_TAG;
              fld_nxt   = '0;
            end
          end
        end else begin
          acc_nxt = acc_or;
          pos_nxt = pos_inc;
        end
      end

      PH_BYTES: begin
        hit              = 1'b1;
        res.kind         = K_IMGBYTE;
        res.value        = {24'd0, data_byte};
        res.field_number = FN_IMAGE;
        res.wire_type    = WT_LEN;
        rem_nxt          = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = PH_TAG;
          acc_nxt   = '0;
          pos_nxt   = '0;
          fld_nxt   = '0;
        end
      end

      PH_FIX: begin
        pos_nxt = pos_inc;
        if (pos_inc >= POS_W'(4)) begin
          hit              = 1'b1;
          res.kind         = K_FLOAT;
          res.value        = acc_fix[31:0];
          res.field_number = FN_FLOAT;
          res.wire_type    = WT_FIXED32;
          phase_nxt        = PH_TAG;
          acc_nxt          = '0;
          pos_nxt          = '0;
          fld_nxt          = '0;
        end else begin
          acc_nxt = acc_fix;
        end
      end

      default: begin
      end
    endcase

    // end of message: report and return to the reset state
    if (last_byte) begin
      if (!hit) begin
        trunc = (phase_nxt == PH_TAG && pos_nxt != '0) || phase_nxt == PH_VAL ||
                phase_nxt == PH_LEN || phase_nxt == PH_BYTES || phase_nxt == PH_FIX;
        res = '0;
        if (trunc) begin
          res.kind         = K_ENDTRUNCATED;
          res.field_number = FN_W'(fld_nxt);
          if (phase_nxt == PH_LEN || phase_nxt == PH_BYTES) begin
            res.wire_type = WT_LEN;
          end else if (phase_nxt == PH_FIX) begin
            res.wire_type = WT_FIXED32;
          end else begin
            res.wire_type = WT_VARINT;
          end
        end else begin
          res.kind = K_ENDCLEAN;
        end
      end
      hit             = 1'b1;
      res.message_end = 1'b1;
      phase_nxt       = PH_TAG;
      acc_nxt         = '0;
      pos_nxt         = '0;
      fld_nxt         = '0;
      rem_nxt         = '0;
    end
  end

  assign res_valid = step && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      acc_r   <= '0;
      pos_r   <= '0;
      fld_r   <= '0;
      rem_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      fld_r   <= fld_nxt;
      rem_r   <= rem_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_bytes_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BYTES |-> rem_r != '0)
    else $error("byte phase with zero bytes remaining");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> phase_r == PH_TAG && pos_r == '0 && acc_r == '0)
    else $error("state not cleared after last byte");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TAG || phase_r == PH_VAL || phase_r == PH_LEN) |->
      pos_r < POS_W'(MAX_VARINT_BYTES))
    else $error("varint byte count out of range");

  a_fix_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FIX |-> pos_r < POS_W'(4))
    else $error("fixed32 byte count out of range");
`endif

endmodule

// File: design/pbdec_obuf.sv
// ----------------------------------------------------------------------------
// pbdec_obuf
// Two-entry output buffer: result register plus skid register.
// ----------------------------------------------------------------------------
module pbdec_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pbdec_pkg::res_t   push_res,
  output logic              ready,
  pbdec_out_if.source       out_if
);
  import pbdec_pkg::*;

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_r;
  res_t skid_r;

  assign ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_if.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_if.ready) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= push_res;
      end else begin
        out_r  <= push_res;
      end
    end else if (push) begin
      skid_r <= push_res;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = out_r.kind;
  assign out_if.value        = out_r.value;
  assign out_if.field_number = out_r.field_number;
  assign out_if.wire_type    = out_r.wire_type;
  assign out_if.message_end  = out_r.message_end;

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty result register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_if.ready |-> !push)
    else $error("word pushed into full buffer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=> out_valid_r && $stable(out_r))
    else $error("result word changed while stalled");
`endif

endmodule

// File: design/protobuf_datum_field_decoder.sv
// ----------------------------------------------------------------------------
// protobuf_datum_field_decoder
// Streaming wire-format decoder for an image record, one byte per word.
// ----------------------------------------------------------------------------
// in_if carries one message byte per word with last_byte marking the final
// byte. out_if carries zero or one decoded record per input byte: field
// values, image length and image bytes, fixed32 float bits, error records,
// and an end record when the last byte gives nothing else.
// Throughput is one byte per cycle while in_if.ready is high: the parser state
// (varint accumulator, byte count, field and remaining length) updates once
// per accepted byte. Each record is registered in the result register, or in
// the skid register while the receiver stalls. in_if.ready drops only while
// both hold words, so a stalled receiver costs at most the input side one
// word of slack before back pressure reaches the source.
// Reset (synchronous, rst_n low) empties both output registers and puts the
// parser back at a field boundary; every last byte does the same to the
// parser state.
// ----------------------------------------------------------------------------
module protobuf_datum_field_decoder (
  input  logic         clk,
  input  logic         rst_n,
  pbdec_in_if.sink     in_if,
  pbdec_out_if.source  out_if
);
  import pbdec_pkg::*;

  logic step;
  logic res_valid;
  logic buf_ready;
  res_t res;

  assign in_if.ready = buf_ready;
  assign step        = in_if.valid && buf_ready;

  pbdec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_if.data_byte),
    .last_byte (in_if.last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  pbdec_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_res (res),
    .ready    (buf_ready),
    .out_if   (out_if)
  );

endmodule

// File: bench/pbdec_record_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbdec_record_checker
// Watches both channels of the image record decoder. Each accepted input
// word goes through a local model of the wire-format parser, and any record
// it yields is queued. Each accepted output word is compared field by field
// with the oldest queued record. Mismatches and unexpected records are
// counted and reported, and the queue depth is handed to the bench top.
// ----------------------------------------------------------------------------
module pbdec_record_checker (
  input  logic  clk,
  input  logic  rst_n,
  pbdec_in_if   in_ch,
  pbdec_out_if  out_ch,
  output int    fail_count,
  output int    pending
);
  import pbdec_pkg::*;

  typedef enum logic [2:0] {
    ST_TAG,
    ST_VALUE,
    ST_LENGTH,
    ST_PAYLOAD,
    ST_FIXED,
    ST_STOPPED
  } parse_t;

  localparam logic [1:0] VI_MORE = 2'd0;
  localparam logic [1:0] VI_DONE = 2'd1;
  localparam logic [1:0] VI_LONG = 2'd2;

  parse_t      ph;
  logic [63:0] accum;
  logic [3:0]  nbyte;
  logic [2:0]  cur_field;
  logic [63:0] remaining;
  res_t        expected_records[$];
  res_t        want;

  function automatic void to_field_boundary();
    ph        = ST_TAG;
    accum     = '0;
    nbyte     = '0;
    cur_field = '0;
  endfunction

  function automatic logic [1:0] feed_varint(input logic [7:0] b);
    int sh;
    sh    = (7 * int'(nbyte)) % 64;
    accum = accum | (64'(b[6:0]) << sh);
    if (!b[7]) return VI_DONE;
    nbyte = nbyte + 4'd1;
    if (int'(nbyte) >= MAX_VARINT_BYTES) return VI_LONG;
    return VI_MORE;
  endfunction

  function automatic res_t make_rec(input kind_t k, input logic [31:0] v,
                                    input logic [FN_W-1:0] fn, input logic [2:0] wt);
    res_t r;
    r.kind         = k;
    r.value        = v;
    r.field_number = fn;
    r.wire_type    = wt;
    r.message_end  = 1'b0;
    return r;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic lst);
    res_t            rec;
    bit              got;
    bit              known;
    logic [1:0]      st;
    logic [FN_W-1:0] fn;
    logic [2:0]      wt;
    logic [2:0]      need;
    parse_t          nxt;
    kind_t           k;
    logic [31:0]     v;
    got   = 1'b0;
    known = 1'b1;
    need  = WT_VARINT;
    nxt   = ST_TAG;
    rec   = '0;
    case (ph)
      ST_TAG: begin
        if (nbyte == 0 && b == 8'h00) begin
          ph = ST_STOPPED;
        end else begin
          st = feed_varint(b);
          if (st == VI_LONG) begin
            rec = make_rec(K_LONGVARINT, '0, '0, WT_VARINT);
            got = 1'b1;
            ph  = ST_STOPPED;
          end else if (st == VI_DONE) begin
            fn = accum[31:3];
            wt = accum[2:0];
            to_field_boundary();
            case (fn)
              FN_CHANNELS, FN_HEIGHT, FN_WIDTH, FN_LABEL, FN_ENCODED: begin
                need = WT_VARINT;
                nxt  = ST_VALUE;
              end
              FN_IMAGE: begin
                need = WT_LEN;
                nxt  = ST_LENGTH;
              end
              FN_FLOAT: begin
                need = WT_FIXED32;
                nxt  = ST_FIXED;
              end
              default: known = 1'b0;
            endcase
            if (!known) begin
              rec = make_rec(K_UNKNOWN, '0, fn, wt);
              got = 1'b1;
              ph  = ST_STOPPED;
            end else if (wt != need) begin
              rec = make_rec(K_BADTYPE, '0, fn, wt);
              got = 1'b1;
            end else begin
              cur_field = fn[2:0];
              ph        = nxt;
            end
          end
        end
      end
      ST_VALUE: begin
        st = feed_varint(b);
        if (st == VI_LONG) begin
          rec = make_rec(K_LONGVARINT, '0, FN_W'(cur_field), WT_VARINT);
          got = 1'b1;
          ph  = ST_STOPPED;
        end else if (st == VI_DONE) begin
          v = accum[31:0];
          case (FN_W'(cur_field))
            FN_CHANNELS: k = K_CHANNELS;
            FN_HEIGHT:   k = K_HEIGHT;
            FN_WIDTH:    k = K_WIDTH;
            FN_LABEL:    k = K_LABEL;
            default: begin
              k = K_ENCODED;
              v = (v != 0) ? 32'd1 : 32'd0;
            end
          endcase
          rec = make_rec(k, v, FN_W'(cur_field), WT_VARINT);
          got = 1'b1;
          to_field_boundary();
        end
      end
      ST_LENGTH: begin
        st = feed_varint(b);
        if (st == VI_LONG) begin
          rec = make_rec(K_LONGVARINT, '0, FN_IMAGE, WT_LEN);
          got = 1'b1;
          ph  = ST_STOPPED;
        end else if (st == VI_DONE) begin
          got = 1'b1;
          if (((accum >> (LENGTH_BITS - 1)) >> 1) != 0) begin
            rec = make_rec(K_BIGLENGTH, accum[31:0], FN_IMAGE, WT_LEN);
            ph  = ST_STOPPED;
          end else begin
            rec       = make_rec(K_IMGLEN, accum[31:0], FN_IMAGE, WT_LEN);
            remaining = accum;
            if (accum != 0) begin
              accum = '0;
              nbyte = '0;
              ph    = ST_PAYLOAD;
            end else begin
              to_field_boundary();
            end
          end
        end
      end
      ST_PAYLOAD: begin
        rec = make_rec(K_IMGBYTE, 32'(b), FN_IMAGE, WT_LEN);
        got = 1'b1;
        if (remaining != 0) remaining = remaining - 64'd1;
        if (remaining == 0) to_field_boundary();
      end
      ST_FIXED: begin
        accum = accum | (64'(b) << (8 * int'(nbyte[1:0])));
        nbyte = nbyte + 4'd1;
        if (nbyte >= 4) begin
          rec = make_rec(K_FLOAT, accum[31:0], FN_FLOAT, WT_FIXED32);
          got = 1'b1;
          to_field_boundary();
        end
      end
      default: ;
    endcase
    if (lst) begin
      if (!got) begin
        if ((ph == ST_TAG && nbyte == 0) || ph == ST_STOPPED) begin
          rec = make_rec(K_ENDCLEAN, '0, '0, WT_VARINT);
        end else begin
          case (ph)
            ST_LENGTH, ST_PAYLOAD: wt = WT_LEN;
            ST_FIXED:              wt = WT_FIXED32;
            default:               wt = WT_VARINT;
          endcase
          rec = make_rec(K_ENDTRUNCATED, '0, FN_W'(cur_field), wt);
        end
        got = 1'b1;
      end
      rec.message_end = 1'b1;
      to_field_boundary();
      remaining = '0;
    end
    if (got) expected_records = {expected_records, rec};
  endfunction

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      to_field_boundary();
      remaining = '0;
      expected_records.delete();
      fail_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected record, expected none, got kind %0d value 0x%0h",
                   $time, out_ch.kind, out_ch.value);
          fail_count++;
        end else begin
          want = expected_records.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_ch.kind));
          check_field("value", want.value, out_ch.value);
          check_field("field_number", 32'(want.field_number), 32'(out_ch.field_number));
          check_field("wire_type", 32'(want.wire_type), 32'(out_ch.wire_type));
          check_field("message_end", 32'(want.message_end), 32'(out_ch.message_end));
        end
      end
    end
    pending = expected_records.size();
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench top of the image record field decoder. Sends a few directed
// messages, then random messages built mostly from well-formed fields with
// random content plus broken and hostile encodings, under random gaps on
// both sides, one long output stall and a drain after each phase. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import pbdec_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RST_CYCLES     = 12;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 400;
  localparam int HOLD_AT        = 150;
  localparam int HOLD_LEN       = 100;
  localparam int RX_CALM_FROM   = 350;
  localparam int RX_CALM_TO     = 500;
  localparam int TX_CALM_FROM   = 250;
  localparam int TX_CALM_TO     = 350;
  localparam int DRAIN_CYCLES   = 10;

  localparam int FLD_MORE = 0;
  localparam int FLD_HALT = 1;
  localparam int FLD_OPEN = 2;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   items_sent   = 0;
  int   rx_cyc       = 0;
  int   quiet_cycles = 0;
  logic [7:0] msg_bytes[$];
  logic [FN_W-1:0] varint_fields[5] = '{FN_CHANNELS, FN_HEIGHT, FN_WIDTH, FN_LABEL,
                                        FN_ENCODED};

  always #(HALF_PERIOD) clk = ~clk;

  pbdec_in_if  in_ch();
  pbdec_out_if out_ch();

  protobuf_datum_field_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  pbdec_record_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver: random stalls, one long hold, one stretch always ready
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_cyc >= HOLD_AT && rx_cyc < HOLD_AT + HOLD_LEN) begin
      out_ch.ready <= 1'b0;
    end else if (rx_cyc >= RX_CALM_FROM && rx_cyc < RX_CALM_TO) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[protobuf_datum_field_decoder] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic lst);
    logic rdy;
    while ((items_sent < TX_CALM_FROM || items_sent >= TX_CALM_TO) &&
           $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    items_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      put_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    msg_bytes = {msg_bytes, b};
  endfunction

  function automatic void push_varint(input logic [63:0] v, input int pad);
    while (v >= 64'd128) begin
      add_byte({1'b1, v[6:0]});
      v = v >> 7;
    end
    if (pad == 0) begin
      add_byte({1'b0, v[6:0]});
    end else begin
      add_byte({1'b1, v[6:0]});
      repeat (pad - 1) add_byte(8'h80);
      add_byte(8'h00);
    end
  endfunction

  function automatic int tag_pad();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int          w;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1, 2: w = 7;
      3:       w = 14;
      4:       w = 21;
      5:       w = 32;
      6:       w = 35;
      default: w = 64;
    endcase
    if (w < 64) v = v & ((64'd1 << w) - 64'd1);
    return v;
  endfunction

  function automatic int add_field();
    int              sel;
    int              n;
    logic [FN_W-1:0] fn;
    logic [2:0]      wt;
    logic [2:0]      need;
    logic [31:0]     hi;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      push_varint(64'({varint_fields[$urandom_range(0, 4)], WT_VARINT}), tag_pad());
      push_varint(rand_value(), 0);
      return FLD_MORE;
    end
    if (sel < 65) begin
      push_varint(64'({FN_IMAGE, WT_LEN}), tag_pad());
      n = $urandom_range(0, 6);
      push_varint(64'(n), 0);
      repeat (n) add_byte(8'($urandom));
      return FLD_MORE;
    end
    if (sel < 80) begin
      push_varint(64'({FN_FLOAT, WT_FIXED32}), tag_pad());
      repeat (4) add_byte(8'($urandom));
      return FLD_MORE;
    end
    if (sel < 88) begin
      fn   = FN_W'($urandom_range(1, 7));
      need = (fn == FN_IMAGE) ? WT_LEN : (fn == FN_FLOAT) ? WT_FIXED32 : WT_VARINT;
      do wt = 3'($urandom_range(0, 7)); while (wt == need);
      push_varint(64'({fn, wt}), tag_pad());
      return FLD_MORE;
    end
    case ($urandom_range(0, 4))
      0: begin
        // unknown field number
        case ($urandom_range(0, 2))
          0:       fn = FN_W'($urandom);
          1:       fn = FN_W'($urandom_range(8, 31));
          default: fn = '0;
        endcase
        if (fn >= 1 && fn <= 7) fn = fn + FN_W'(8);
        push_varint(64'({fn, 3'($urandom_range(0, 7))}), tag_pad());
      end
      1: add_byte(8'h00);
      2: begin
        // varint that never ends: in the tag, a value or a length
        case ($urandom_range(0, 2))
          0: ;
          1: push_varint(64'({varint_fields[$urandom_range(0, 4)], WT_VARINT}), 0);
          default: push_varint(64'({FN_IMAGE, WT_LEN}), 0);
        endcase
        repeat (MAX_VARINT_BYTES) add_byte(8'h80 | 8'($urandom_range(0, 127)));
      end
      3: begin
        push_varint(64'({FN_IMAGE, WT_LEN}), 0);
        hi = $urandom;
        if (hi == 0) hi = 32'd1;
        push_varint({hi, $urandom}, 0);
      end
      default: begin
        // large length, message cut inside the payload
        push_varint(64'({FN_IMAGE, WT_LEN}), 0);
        push_varint(64'($urandom | 32'h100), 0);
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
        return FLD_OPEN;
      end
    endcase
    return FLD_HALT;
  endfunction

  function automatic int build_message();
    int nf;
    int st;
    int useful;
    int cut;
    msg_bytes.delete();
    nf = $urandom_range(1, 6);
    st = FLD_MORE;
    for (int k = 0; k < nf && st == FLD_MORE; k++) st = add_field();
    useful = msg_bytes.size();
    if (st == FLD_HALT) repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    if ($urandom_range(0, 9) == 0 && msg_bytes.size() > 1) begin
      cut = $urandom_range(1, msg_bytes.size() - 1);
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      if (useful > cut) useful = cut;
    end
    return useful;
  endfunction

  initial begin
    int total;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // channels, image, float, label and encoded fields, then an unknown one and a byte after the stop
    msg_bytes = '{8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
                  8'h22, 8'h02, 8'h00, 8'hFF,
                  8'h35, 8'h00, 8'hFF, 8'h80, 8'h7F,
                  8'h28, 8'h05, 8'h38, 8'h00, 8'h40, 8'h10};
    send_message();
    // zero tag
    msg_bytes = '{8'h00};
    send_message();
    // wrong wire type on the last byte
    msg_bytes = '{8'h09};
    send_message();
    // message ends inside a value
    msg_bytes = '{8'h18, 8'h80};
    send_message();
    // empty image
    msg_bytes = '{8'h22, 8'h00};
    send_message();
    in_ch.valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    total = 0;
    while (total < RANDOM_ITEMS) begin
      total += build_message();
      send_message();
    end
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[protobuf_datum_field_decoder] OK");
    end else begin
      $display("[protobuf_datum_field_decoder] ERROR");
    end
    $finish;
  end

endmodule
